FILE: rtl/tbpq_pkg.sv
// Shared types and constants for the two-band port priority queue.
package tbpq_pkg;

    // Word field widths
    localparam int OP_W      = 2;
    localparam int PORT_W    = 16;
    localparam int REF_W     = 32;
    localparam int LEN_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 12;
    localparam int BACKLOG_W = 27;
    localparam int DROPS_W   = 32;
    localparam int LIMIT_W   = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PORT_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd2;

    localparam logic [PORT_W-1:0]  PORT_LOW_RST    = 16'd5000;
    localparam logic [PORT_W-1:0]  PORT_HIGH_RST   = 16'd6000;
    localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST = 11'd1000;

    // Operation codes; the unused code acts as a peek
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED  = 2'd0,
        ST_DROPPED = 2'd1,
        ST_GIVEN   = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } fsm_t;

    // One stored packet descriptor
    typedef struct packed {
        logic [REF_W-1:0] pkt_ref;
        logic [LEN_W-1:0] pkt_len;
    } entry_t;

endpackage

FILE: rtl/tbpq_if.sv
// Request and response channel interfaces of the two-band port priority queue.
interface tbpq_req_if;
    import tbpq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [PORT_W-1:0] source_port;
    logic [REF_W-1:0]  packet_ref;
    logic [LEN_W-1:0]  packet_length;

    modport source (output valid, operation, source_port, packet_ref, packet_length,
                    input ready);
    modport sink   (input valid, operation, source_port, packet_ref, packet_length,
                    output ready);
endinterface

interface tbpq_rsp_if;
    import tbpq_pkg::*;

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic                 band;
    logic [REF_W-1:0]     out_packet_ref;
    logic [LEN_W-1:0]     out_packet_length;
    logic [TOTAL_W-1:0]   total_packets;
    logic [BACKLOG_W-1:0] backlog_bytes;
    logic [DROPS_W-1:0]   drop_count;

    modport source (output valid, status, band, out_packet_ref, out_packet_length,
                    total_packets, backlog_bytes, drop_count,
                    input ready);
    modport sink   (input valid, status, band, out_packet_ref, out_packet_length,
                    total_packets, backlog_bytes, drop_count,
                    output ready);
endinterface

FILE: rtl/two_band_port_priority_queue_unit.sv
// Two-band strict-priority packet queue classified by TCP source port.
// An enqueue, or a dequeue/peek on empty bands, is answered the cycle after acceptance;
// a dequeue/peek that finds a packet passes the RAM read register, then the response register.
// Throughput: one enqueue per cycle while rsp.ready holds; no word is taken during a RAM read.
// Reset (rst_n, async low) empties both bands, clears totals and drops, restores registers;
// the descriptor RAM is not cleared, so no clearing pass is needed.
module two_band_port_priority_queue_unit #(
    parameter int BAND_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tbpq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbpq_pkg::CFG_DATA_W-1:0] cfg_data,
    tbpq_req_if.sink                      req,
    tbpq_rsp_if.source                    rsp
);
    import tbpq_pkg::*;

    localparam int IDX_W     = $clog2(BAND_DEPTH);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 << IDX_W;
    localparam int CNT_W     = $clog2(BAND_DEPTH + 1);
    localparam int CMP_W     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BAND_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(BAND_DEPTH);

    // Descriptor RAM: band in the top address bit
    entry_t mem [MEM_DEPTH];
    entry_t rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            wr_entry;

    // Configuration registers
    logic [PORT_W-1:0]  port_low_reg, port_low_next;
    logic [PORT_W-1:0]  port_high_reg, port_high_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;

    // Queue state
    logic [IDX_W-1:0]     head_reg [2];
    logic [IDX_W-1:0]     head_next [2];
    logic [IDX_W-1:0]     tail_reg [2];
    logic [IDX_W-1:0]     tail_next [2];
    logic [CNT_W-1:0]     count_reg [2];
    logic [CNT_W-1:0]     count_next [2];
    logic [BACKLOG_W-1:0] backlog_reg, backlog_next;
    logic [DROPS_W-1:0]   drops_reg, drops_next;

    // Sequencer
    fsm_t state_reg, state_next;
    logic rd_band_reg, rd_band_next;
    logic take_reg, take_next;

    // Response register
    logic                 rsp_valid_reg, rsp_valid_next;
    status_t              rsp_status_reg, rsp_status_next;
    logic                 rsp_band_reg, rsp_band_next;
    logic [REF_W-1:0]     rsp_ref_reg, rsp_ref_next;
    logic [LEN_W-1:0]     rsp_len_reg, rsp_len_next;
    logic [TOTAL_W-1:0]   rsp_total_reg, rsp_total_next;
    logic [BACKLOG_W-1:0] rsp_backlog_reg, rsp_backlog_next;
    logic [DROPS_W-1:0]   rsp_drops_reg, rsp_drops_next;

    logic accept;
    logic in_ready;

    // Sequencer outputs: take a word only when idle and the response slot frees up
    always_comb
    begin
        in_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    end

    assign req.ready = in_ready;
    assign accept    = req.valid && in_ready;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.operation != OP_ENQUEUE) &&
                    ((count_reg[0] != '0) || (count_reg[1] != '0)))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath: classify, update counters, load the response register
    always_comb
    begin
        logic           enq_band;
        logic           full;
        logic           srv_band;
        logic           any_pkt;
        logic [CNT_W-1:0] cnt_sel;

        port_low_next    = port_low_reg;
        port_high_next   = port_high_reg;
        limit_next       = limit_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        backlog_next     = backlog_reg;
        drops_next       = drops_reg;
        rd_band_next     = rd_band_reg;
        take_next        = take_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_status_next  = rsp_status_reg;
        rsp_band_next    = rsp_band_reg;
        rsp_ref_next     = rsp_ref_reg;
        rsp_len_next     = rsp_len_reg;
        rsp_total_next   = rsp_total_reg;
        rsp_backlog_next = rsp_backlog_reg;
        rsp_drops_next   = rsp_drops_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        wr_entry.pkt_ref = req.packet_ref;
        wr_entry.pkt_len = req.packet_length;

        // Band 0 for ports inside the configured range
        enq_band = !((req.source_port >= port_low_reg) && (req.source_port <= port_high_reg));
        cnt_sel  = count_reg[enq_band];
        full     = (CMP_W'(cnt_sel) >= CMP_W'(limit_reg)) || (cnt_sel >= CNT_CAP);
        any_pkt  = (count_reg[0] != '0) || (count_reg[1] != '0);
        srv_band = (count_reg[0] == '0);

        wr_addr = {enq_band, tail_reg[enq_band]};
        rd_addr = {srv_band, head_reg[srv_band]};

        // Write configuration
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PORT_LOW:    port_low_next  = cfg_data[PORT_W-1:0];
                CFG_PORT_HIGH:   port_high_next = cfg_data[PORT_W-1:0];
                CFG_QUEUE_LIMIT: limit_next     = cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end

        if (accept)
        begin
            if (req.operation == OP_ENQUEUE)
            begin
                rsp_valid_next  = 1'b1;
                rsp_band_next   = enq_band;
                rsp_ref_next    = '0;
                rsp_len_next    = '0;
                if (full)
                begin
                    // Drop and count
                    drops_next      = drops_reg + 1'b1;
                    rsp_status_next = ST_DROPPED;
                end
                else
                begin
                    // Store descriptor at tail and advance
                    mem_we              = 1'b1;
                    tail_next[enq_band] = (tail_reg[enq_band] == IDX_LAST) ? '0 :
                                          tail_reg[enq_band] + 1'b1;
                    count_next[enq_band] = count_reg[enq_band] + 1'b1;
                    backlog_next    = backlog_reg + BACKLOG_W'(req.packet_length);
                    rsp_status_next = ST_QUEUED;
                end
                rsp_total_next   = TOTAL_W'(count_next[0]) + TOTAL_W'(count_next[1]);
                rsp_backlog_next = backlog_next;
                rsp_drops_next   = drops_next;
            end
            else if (any_pkt)
            begin
                // Fetch head of the served band
                mem_re       = 1'b1;
                rd_band_next = srv_band;
                take_next    = (req.operation == OP_DEQUEUE);
            end
            else
            begin
                // Nothing queued
                rsp_valid_next   = 1'b1;
                rsp_status_next  = ST_EMPTY;
                rsp_band_next    = 1'b0;
                rsp_ref_next     = '0;
                rsp_len_next     = '0;
                rsp_total_next   = '0;
                rsp_backlog_next = backlog_reg;
                rsp_drops_next   = drops_reg;
            end
        end

        // Finish a dequeue or peek with the fetched descriptor
        if (state_reg == S_READ)
        begin
            if (take_reg)
            begin
                head_next[rd_band_reg]  = (head_reg[rd_band_reg] == IDX_LAST) ? '0 :
                                          head_reg[rd_band_reg] + 1'b1;
                count_next[rd_band_reg] = count_reg[rd_band_reg] - 1'b1;
                backlog_next = backlog_reg - BACKLOG_W'(rd_data_reg.pkt_len);
            end
            rsp_valid_next   = 1'b1;
            rsp_status_next  = ST_GIVEN;
            rsp_band_next    = rd_band_reg;
            rsp_ref_next     = rd_data_reg.pkt_ref;
            rsp_len_next     = rd_data_reg.pkt_len;
            rsp_total_next   = TOTAL_W'(count_next[0]) + TOTAL_W'(count_next[1]);
            rsp_backlog_next = backlog_next;
            rsp_drops_next   = drops_reg;
        end
    end

    // Descriptor RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_low_reg   <= PORT_LOW_RST;
            port_high_reg  <= PORT_HIGH_RST;
            limit_reg      <= QUEUE_LIMIT_RST;
            head_reg[0]    <= '0;
            head_reg[1]    <= '0;
            tail_reg[0]    <= '0;
            tail_reg[1]    <= '0;
            count_reg[0]   <= '0;
            count_reg[1]   <= '0;
            backlog_reg    <= '0;
            drops_reg      <= '0;
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            port_low_reg   <= port_low_next;
            port_high_reg  <= port_high_next;
            limit_reg      <= limit_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            backlog_reg    <= backlog_next;
            drops_reg      <= drops_next;
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_band_reg     <= rd_band_next;
        take_reg        <= take_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_band_reg    <= rsp_band_next;
        rsp_ref_reg     <= rsp_ref_next;
        rsp_len_reg     <= rsp_len_next;
        rsp_total_reg   <= rsp_total_next;
        rsp_backlog_reg <= rsp_backlog_next;
        rsp_drops_reg   <= rsp_drops_next;
    end

    // Drive the response channel
    assign rsp.valid             = rsp_valid_reg;
    assign rsp.status            = rsp_status_reg;
    assign rsp.band              = rsp_band_reg;
    assign rsp.out_packet_ref    = rsp_ref_reg;
    assign rsp.out_packet_length = rsp_len_reg;
    assign rsp.total_packets     = rsp_total_reg;
    assign rsp.backlog_bytes     = rsp_backlog_reg;
    assign rsp.drop_count        = rsp_drops_reg;

endmodule

FILE: rtl/tbpq_checker.sv
// Port-level checks for the two-band port priority queue, bound to the top level.
module tbpq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic [tbpq_pkg::OP_W-1:0]       req_operation,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [tbpq_pkg::STATUS_W-1:0]   rsp_status,
    input logic                            rsp_band,
    input logic [tbpq_pkg::REF_W-1:0]      rsp_out_packet_ref,
    input logic [tbpq_pkg::LEN_W-1:0]      rsp_out_packet_length,
    input logic [tbpq_pkg::TOTAL_W-1:0]    rsp_total_packets,
    input logic [tbpq_pkg::BACKLOG_W-1:0]  rsp_backlog_bytes
);
    import tbpq_pkg::*;

    // Hold a stalled response word
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_out_packet_ref) && $stable(rsp_total_packets))
        else $error("stalled response word changed");

    // An accepted enqueue answers on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_operation == OP_ENQUEUE) |=> rsp_valid)
        else $error("enqueue result not presented one cycle after acceptance");

    // Enqueue results carry no descriptor
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == ST_QUEUED) || (rsp_status == ST_DROPPED)) |->
        (rsp_out_packet_ref == '0) && (rsp_out_packet_length == '0))
        else $error("enqueue result carries a descriptor");

    // Empty answer means nothing held at all
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_EMPTY) |->
        !rsp_band && (rsp_total_packets == '0) && (rsp_backlog_bytes == '0))
        else $error("empty result with packets or bytes still held");

endmodule

bind two_band_port_priority_queue_unit tbpq_checker u_tbpq_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .req_valid             (req.valid),
    .req_ready             (req.ready),
    .req_operation         (req.operation),
    .rsp_valid             (rsp.valid),
    .rsp_ready             (rsp.ready),
    .rsp_status            (rsp.status),
    .rsp_band              (rsp.band),
    .rsp_out_packet_ref    (rsp.out_packet_ref),
    .rsp_out_packet_length (rsp.out_packet_length),
    .rsp_total_packets     (rsp.total_packets),
    .rsp_backlog_bytes     (rsp.backlog_bytes)
);

FILE: tb/two_band_port_priority_queue_unit_check.sv
// Watches both channels of the two-band queue, predicts each result word and compares it.
module two_band_port_priority_queue_unit_check #(
    parameter int DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tbpq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbpq_pkg::CFG_DATA_W-1:0] cfg_data,
    tbpq_req_if                             req,
    tbpq_rsp_if                             rsp,
    output int                              mismatches,
    output int                              pending,
    output int                              results_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import tbpq_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        status_t              status;
        logic                 band;
        logic [REF_W-1:0]     pkt_ref;
        logic [LEN_W-1:0]     pkt_len;
        logic [TOTAL_W-1:0]   total;
        logic [BACKLOG_W-1:0] backlog;
        logic [DROPS_W-1:0]   drops;
    } queue_result_t;

    // Shadow of the block: configuration, descriptor storage and totals
    logic [PORT_W-1:0]    port_lo = PORT_LOW_RST;
    logic [PORT_W-1:0]    port_hi = PORT_HIGH_RST;
    logic [LIMIT_W-1:0]   band_limit = QUEUE_LIMIT_RST;
    logic [REF_W-1:0]     desc_ref [2][DEPTH];
    logic [LEN_W-1:0]     desc_len [2][DEPTH];
    int                   rd_ptr [2] = '{0, 0};
    int                   wr_ptr [2] = '{0, 0};
    int                   fill [2] = '{0, 0};
    logic [BACKLOG_W-1:0] bytes_held = '0;
    logic [DROPS_W-1:0]   drop_total = '0;

    queue_result_t expected_words [$];
    int errors = 0;
    int compared = 0;

    assign mismatches      = errors;
    assign pending         = expected_words.size();
    assign results_checked = compared;

    // Advance the shadow by one request word and return the result it must produce
    function automatic queue_result_t serve_word(logic [OP_W-1:0] op, logic [PORT_W-1:0] port,
                                                 logic [REF_W-1:0] pref, logic [LEN_W-1:0] plen);
        queue_result_t r;
        int b;
        int lim;
        r = '0;
        r.status = ST_EMPTY;
        if (op == OP_ENQUEUE) begin
            b = (port >= port_lo && port <= port_hi) ? 0 : 1;
            lim = (band_limit > DEPTH) ? DEPTH : band_limit;
            r.band = b[0];
            if (fill[b] >= lim) begin
                drop_total = drop_total + 1;
                r.status = ST_DROPPED;
            end else begin
                desc_ref[b][wr_ptr[b]] = pref;
                desc_len[b][wr_ptr[b]] = plen;
                wr_ptr[b] = (wr_ptr[b] + 1) % DEPTH;
                fill[b]++;
                bytes_held = bytes_held + plen;
                r.status = ST_QUEUED;
            end
        end else begin
            // Strict priority: band 0 first; any non-dequeue code only looks
            b = (fill[0] != 0) ? 0 : ((fill[1] != 0) ? 1 : -1);
            if (b >= 0) begin
                r.status  = ST_GIVEN;
                r.band    = b[0];
                r.pkt_ref = desc_ref[b][rd_ptr[b]];
                r.pkt_len = desc_len[b][rd_ptr[b]];
                if (op == OP_DEQUEUE) begin
                    rd_ptr[b] = (rd_ptr[b] + 1) % DEPTH;
                    fill[b]--;
                    bytes_held = bytes_held - r.pkt_len;
                end
            end
        end
        r.total   = TOTAL_W'(fill[0] + fill[1]);
        r.backlog = bytes_held;
        r.drops   = drop_total;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("MISMATCH at %0t ns, result %0d, %s: got 0x%0h, want 0x%0h",
                     $time, compared, what, got, want);
    endtask

    // Compare one accepted result word with the oldest prediction
    task automatic compare_word();
        queue_result_t want;
        compared++;
        if (expected_words.size() == 0) begin
            report_mismatch("result word with nothing pending", rsp.status, 0);
            return;
        end
        want = expected_words.pop_front();
        if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
        if (rsp.band !== want.band)
            report_mismatch("band", rsp.band, want.band);
        if (rsp.out_packet_ref !== want.pkt_ref)
            report_mismatch("out_packet_ref", rsp.out_packet_ref, want.pkt_ref);
        if (rsp.out_packet_length !== want.pkt_len)
            report_mismatch("out_packet_length", rsp.out_packet_length, want.pkt_len);
        if (rsp.total_packets !== want.total)
            report_mismatch("total_packets", rsp.total_packets, want.total);
        if (rsp.backlog_bytes !== want.backlog)
            report_mismatch("backlog_bytes", rsp.backlog_bytes, want.backlog);
        if (rsp.drop_count !== want.drops)
            report_mismatch("drop_count", rsp.drop_count, want.drops);
    endtask

    // Track register writes, check results, then predict newly accepted requests
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            port_lo    = PORT_LOW_RST;
            port_hi    = PORT_HIGH_RST;
            band_limit = QUEUE_LIMIT_RST;
            rd_ptr     = '{0, 0};
            wr_ptr     = '{0, 0};
            fill       = '{0, 0};
            bytes_held = '0;
            drop_total = '0;
            expected_words.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PORT_LOW:    port_lo = cfg_data[PORT_W-1:0];
                    CFG_PORT_HIGH:   port_hi = cfg_data[PORT_W-1:0];
                    CFG_QUEUE_LIMIT: band_limit = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                compare_word();
            if (req.valid === 1'b1 && req.ready === 1'b1)
                expected_words.push_back(serve_word(req.operation, req.source_port,
                                                    req.packet_ref, req.packet_length));
        end
    end

endmodule

FILE: tb/two_band_port_priority_queue_unit_tb.sv
// Top of the two-band queue testbench: clock, reset, stimulus, register writes and verdict.
module two_band_port_priority_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tbpq_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int IDLE_PCT     = 23;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int results_checked;

    bit steady = 1'b0;
    bit hold_off_req = 1'b0;
    int n_enq = 0;
    int n_deq = 0;
    int n_peek = 0;
    int n_settings = 1;
    logic [PORT_W-1:0] cur_lo = PORT_LOW_RST;
    logic [PORT_W-1:0] cur_hi = PORT_HIGH_RST;

    tbpq_req_if req_ch ();
    tbpq_rsp_if rsp_ch ();

    two_band_port_priority_queue_unit #(.BAND_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    two_band_port_priority_queue_unit_check #(.DEPTH(DEPTH)) queue_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // 125 MHz clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Response side: random back-pressure, or one long hold-off on request
    initial begin : response_sink
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // End the run when no word or register write moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one request word, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_word(logic [OP_W-1:0] op, logic [PORT_W-1:0] port,
                             logic [REF_W-1:0] pref, logic [LEN_W-1:0] plen);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.source_port   <= port;
        req_ch.packet_ref    <= pref;
        req_ch.packet_length <= plen;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        case (op)
            OP_ENQUEUE: n_enq++;
            OP_DEQUEUE: n_deq++;
            default:    n_peek++;
        endcase
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    // Write all three registers while the block is idle
    task automatic configure(logic [PORT_W-1:0] lo, logic [PORT_W-1:0] hi,
                             logic [CFG_DATA_W-1:0] limit_data);
        settle();
        write_reg(CFG_PORT_LOW, lo);
        write_reg(CFG_PORT_HIGH, hi);
        write_reg(CFG_QUEUE_LIMIT, limit_data);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
        n_settings++;
    endtask

    // Random words with the given operation mix; ports aim at the range and its edges, or anywhere
    task automatic random_phase(int n, int enq_pct, int deq_pct, int steady_n, int hold_at);
        int r;
        logic [OP_W-1:0]   op;
        logic [PORT_W-1:0] port;
        logic [REF_W-1:0]  pref;
        logic [LEN_W-1:0]  plen;
        for (int i = 0; i < n; i++) begin
            steady = (i < steady_n);
            if (i == hold_at)
                hold_off_req = 1'b1;
            r = $urandom_range(99);
            if (r < enq_pct)
                op = OP_ENQUEUE;
            else if (r < enq_pct + deq_pct)
                op = OP_DEQUEUE;
            else
                op = ($urandom_range(9) == 0) ? OP_UNUSED : OP_PEEK;
            r = $urandom_range(99);
            case ($urandom_range(3))
                0: port = cur_lo;
                1: port = cur_hi;
                2: port = cur_lo - 1'b1;
                default: port = cur_hi + 1'b1;
            endcase
            if (r >= 10 && r < 55 && cur_lo <= cur_hi)
                port = PORT_W'($urandom_range(cur_hi, cur_lo));
            else if (r >= 55)
                port = PORT_W'($urandom_range(16'hFFFF));
            r = $urandom_range(99);
            pref = (r < 5) ? '0 : ((r < 10) ? '1 : $urandom);
            r = $urandom_range(99);
            plen = (r < 5) ? '0 : ((r < 10) ? '1 : LEN_W'($urandom_range(16'hFFFF)));
            send_word(op, port, pref, plen);
        end
        steady = 1'b0;
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = CFG_PORT_LOW;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_ENQUEUE;
        req_ch.source_port   = '0;
        req_ch.packet_ref    = '0;
        req_ch.packet_length = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty queue on every non-enqueue code
        send_word(OP_PEEK, 16'd0, 32'd0, 16'd0);
        send_word(OP_DEQUEUE, 16'd0, 32'd0, 16'd0);
        send_word(OP_UNUSED, 16'hFFFF, '1, '1);

        // Range edges at the reset setting, then drain in priority order
        send_word(OP_ENQUEUE, 16'd5000, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_ENQUEUE, 16'd4999, 32'h1357_9BDF, 16'd1500);
        send_word(OP_ENQUEUE, 16'd6000, 32'h0000_0000, 16'd0);
        send_word(OP_ENQUEUE, 16'd6001, 32'hA5A5_5A5A, 16'd64);
        send_word(OP_ENQUEUE, 16'd0, 32'h8000_0001, 16'd9000);
        send_word(OP_ENQUEUE, 16'hFFFF, 32'h7FFF_FFFE, 16'd40);
        send_word(OP_PEEK, 16'd0, 32'd0, 16'd0);
        send_word(OP_UNUSED, 16'd0, 32'd0, 16'd0);
        repeat (7) send_word(OP_DEQUEUE, 16'd0, 32'd0, 16'd0);

        // Zero limit drops everything
        configure(16'd0, 16'hFFFF, 16'd0);
        send_word(OP_ENQUEUE, 16'd0, 32'h1111_1111, 16'd100);
        send_word(OP_ENQUEUE, 16'hFFFF, 32'h2222_2222, 16'd200);

        // Empty port range sends all to band 1; limit of one
        configure(16'hFFFF, 16'd0, 16'd1);
        send_word(OP_ENQUEUE, 16'hFFFF, 32'hCAFE_0001, 16'd77);
        send_word(OP_ENQUEUE, 16'd0, 32'hCAFE_0002, 16'd88);
        send_word(OP_UNUSED, 16'd0, 32'd0, 16'd0);
        send_word(OP_DEQUEUE, 16'd0, 32'd0, 16'd0);
        send_word(OP_DEQUEUE, 16'd0, 32'd0, 16'd0);

        // Small limit, junk above the limit field, a steady stretch first
        configure(16'd1000, 16'd30000, 16'hF804);
        random_phase(250, 55, 30, 120, -1);

        // Everything in band 0; hold off the response side so the block fills and stalls
        configure(16'd0, 16'hFFFF, 16'd16);
        random_phase(250, 60, 25, 0, 40);

        // Limit above capacity: fill band 1 past its depth
        configure(16'd40000, 16'd39999, 16'h07FF);
        random_phase(1080, 99, 1, 0, -1);

        // Limit at capacity, single-port band 0, mostly draining
        configure(16'd0, 16'd0, 16'd1024);
        random_phase(200, 25, 65, 0, -1);

        settle();
        $display("Covered %0d words: %0d enqueues, %0d dequeues, %0d peeks over %0d settings.",
                 n_enq + n_deq + n_peek, n_enq, n_deq, n_peek, n_settings);
        $display("Compared %0d result words, with one %0d-cycle response hold-off.",
                 results_checked, HOLD_CYCLES);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: two_band_port_priority_queue_unit.f
rtl/tbpq_pkg.sv
rtl/tbpq_if.sv
rtl/two_band_port_priority_queue_unit.sv
rtl/tbpq_checker.sv
tb/two_band_port_priority_queue_unit_check.sv
tb/two_band_port_priority_queue_unit_tb.sv
